### rtl/wftok_pkg.sv
package wftok_pkg;

  // Field widths of one request and one record
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned FIELD_W = 61;
  localparam int unsigned VALUE_W = 64;

  // Default depth of the record queue; must be at least 2
  localparam int unsigned WFT_FIFO_DEPTH = 4;

  // Record kinds
  localparam logic [KIND_W-1:0] KIND_VARINT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIXED64  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEXT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NESTED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIXED32  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_TRUNC    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_OVERLONG = 3'd7;

  // Wire types as they appear in the low three bits of a tag
  localparam logic [2:0] WT_VARINT      = 3'd0;
  localparam logic [2:0] WT_FIXED64     = 3'd1;
  localparam logic [2:0] WT_LENGTH      = 3'd2;
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_FIXED32     = 3'd5;
  localparam logic [2:0] WT_UNUSED_6    = 3'd6;
  localparam logic [2:0] WT_UNUSED_7    = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] field;
    logic [VALUE_W-1:0] value;
    logic               last;
  } record_t;

  // Up to two records produced by one request; push1 implies push0
  typedef struct packed {
    logic    push0;
    logic    push1;
    record_t rec0;
    record_t rec1;
  } push_t;

endpackage

### rtl/wire_format_field_tokenizer_unit.sv
// Wire-format field tokenizer.
// Request channel (item_valid / item_stall): one message byte per request,
// with end_of_buffer set on the last byte of the buffer.
// Record channel (record_valid / record_stall): tagged records carrying
// record_kind, field_number, field_value; last_of_item marks the final
// record caused by one request (a byte causes zero, one or two records).
// Throughput: one request per cycle while item_stall is low. Each byte is parsed
// in the cycle it is accepted and its records are written into a small record
// queue, from whose head the record channel reads.
// item_stall rises when fewer than two queue entries are free; while the
// receiver stalls, the queue fills and the head record holds steady.
// A byte that causes two records presents them on the output one after the other.
// Reset (rst, synchronous): the parser returns to expecting a tag, all
// accumulators clear, and the record queue empties.
module wire_format_field_tokenizer_unit
  import wftok_pkg::*;
#(
  parameter int unsigned FifoDepth = WFT_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               end_of_buffer,
  output logic               record_valid,
  input  logic               record_stall,
  output logic [KIND_W-1:0]  record_kind,
  output logic [FIELD_W-1:0] field_number,
  output logic [VALUE_W-1:0] field_value,
  output logic               last_of_item
);

  logic    take;
  logic    full2;
  push_t   push;
  record_t head;

  assign take       = item_valid && !full2;
  assign item_stall = full2;

  wftok_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .push          (push)
  );

  wftok_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full2    (full2),
    .rd_valid (record_valid),
    .rd_take  (!record_stall),
    .rd_rec   (head)
  );

  assign record_kind  = head.kind;
  assign field_number = head.field;
  assign field_value  = head.value;
  assign last_of_item = head.last;

endmodule

### rtl/wftok_core.sv
module wftok_core
  import wftok_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_buffer,
  output push_t             push
);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_FIXED   = 3'd4;

  logic [2:0]         phase, phase_next;
  logic [63:0]        acc, acc_next;
  logic [3:0]         cnt, cnt_next;
  logic [FIELD_W-1:0] fld, fld_next;
  logic [2:0]         wt, wt_next;
  logic [63:0]        rem, rem_next;
  logic [63:0]        plen, plen_next;
  logic [63:0]        fix, fix_next;
  logic [2:0]         u_pend, u_pend_next;
  logic               u_valid, u_valid_next;
  logic               u_stop, u_stop_next;

  logic [6:0]  shamt;
  logic [63:0] vacc;
  logic [3:0]  vcnt;
  logic        vdone, vover;
  logic [63:0] rem_dec;
  logic [2:0]  fix_idx;
  logic [63:0] fix_new;
  logic        p0, p1;
  record_t     r0, r1;

  // Varint byte folded into the accumulator
  assign shamt   = {cnt, 3'b000} - {3'b000, cnt};
  assign vacc    = acc | ({57'd0, data_byte[6:0]} << shamt);
  assign vcnt    = cnt + 4'd1;
  assign vdone   = !data_byte[7];
  assign vover   = data_byte[7] && (vcnt >= 4'd10);
  assign rem_dec = rem - 64'd1;
  assign fix_idx = ((wt == WT_FIXED32) ? 3'd4 : 3'd0) - rem[2:0];
  assign fix_new = fix | ({56'd0, data_byte} << {fix_idx, 3'b000});

  always_comb begin
    phase_next   = phase;
    acc_next     = acc;
    cnt_next     = cnt;
    fld_next     = fld;
    wt_next      = wt;
    rem_next     = rem;
    plen_next    = plen;
    fix_next     = fix;
    u_pend_next  = u_pend;
    u_valid_next = u_valid;
    u_stop_next  = u_stop;
    p0 = 1'b0;
    p1 = 1'b0;
    r0 = '0;
    r1 = '0;

    case (phase)
      PH_TAG: begin
        if (vover) begin
          p0 = 1'b1;
          r0.kind  = KIND_OVERLONG;
          r0.value = vacc;
          phase_next = PH_TAG;
          acc_next = '0; cnt_next = '0; fld_next = '0; wt_next = '0;
          rem_next = '0; fix_next = '0;
        end else if (vdone) begin
          acc_next = '0; cnt_next = '0; fix_next = '0;
          fld_next = vacc[63:3];
          wt_next  = vacc[2:0];
          rem_next = '0;
          case (vacc[2:0])
            WT_VARINT:  phase_next = PH_VALUE;
            WT_LENGTH:  phase_next = PH_LENGTH;
            WT_FIXED64: begin
              phase_next = PH_FIXED;
              rem_next   = 64'd8;
            end
            WT_FIXED32: begin
              phase_next = PH_FIXED;
              rem_next   = 64'd4;
            end
            default: begin
              // Unknown wire type: drop the tag
              phase_next = PH_TAG;
              fld_next   = '0;
              wt_next    = '0;
            end
          endcase
        end else begin
          acc_next = vacc;
          cnt_next = vcnt;
        end
      end

      PH_VALUE, PH_LENGTH: begin
        if (vover || (vdone && phase == PH_VALUE)) begin
          p0 = 1'b1;
          r0.kind  = vover ? KIND_OVERLONG : KIND_VARINT;
          r0.field = fld;
          r0.value = vacc;
          phase_next = PH_TAG;
          acc_next = '0; cnt_next = '0; fld_next = '0; wt_next = '0;
          rem_next = '0; fix_next = '0;
        end else if (vdone) begin
          // Length complete: open the payload (or emit an empty text record) and restart the text check
          plen_next    = vacc;
          rem_next     = vacc;
          acc_next     = '0;
          cnt_next     = '0;
          u_pend_next  = '0;
          u_valid_next = 1'b1;
          u_stop_next  = 1'b0;
          if (vacc == 64'd0) begin
            p0 = 1'b1;
            r0.kind  = KIND_TEXT;
            r0.field = fld;
            phase_next = PH_TAG;
            fld_next = '0; wt_next = '0; rem_next = '0; fix_next = '0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          acc_next = vacc;
          cnt_next = vcnt;
        end
      end

      PH_PAYLOAD: begin
        p0 = 1'b1;
        r0.kind  = KIND_PAYLOAD;
        r0.field = fld;
        r0.value = {56'd0, data_byte};
        // Lenient UTF-8 check, frozen after a zero byte or a failure
        if (!u_stop && u_valid) begin
          if (data_byte == 8'h00) begin
            u_stop_next = 1'b1;
          end else if (u_pend == 3'd0) begin
            if (data_byte inside {[8'hFC:8'hFD]})      u_pend_next = 3'd5;
            else if (data_byte inside {[8'hF8:8'hFF]}) u_pend_next = 3'd4;
            else if (data_byte inside {[8'hF0:8'hF7]}) u_pend_next = 3'd3;
            else if (data_byte inside {[8'hE0:8'hEF]}) u_pend_next = 3'd2;
            else if (data_byte inside {[8'hC0:8'hDF]}) u_pend_next = 3'd1;
            else if (data_byte[7])                     u_valid_next = 1'b0;
          end else if (data_byte[7:6] != 2'b10) begin
            u_valid_next = 1'b0;
          end else begin
            u_pend_next = u_pend - 3'd1;
          end
        end
        rem_next = rem_dec;
        if (rem_dec == 64'd0) begin
          p1 = 1'b1;
          r1.kind  = (u_valid_next && u_pend_next == 3'd0) ? KIND_TEXT : KIND_NESTED;
          r1.field = fld;
          r1.value = plen;
          phase_next = PH_TAG;
          acc_next = '0; cnt_next = '0; fld_next = '0; wt_next = '0;
          rem_next = '0; fix_next = '0;
        end
      end

      PH_FIXED: begin
        fix_next = fix_new;
        rem_next = rem_dec;
        if (rem_dec == 64'd0) begin
          p0 = 1'b1;
          r0.kind  = (wt == WT_FIXED32) ? KIND_FIXED32 : KIND_FIXED64;
          r0.field = fld;
          r0.value = fix_new;
          phase_next = PH_TAG;
          acc_next = '0; cnt_next = '0; fld_next = '0; wt_next = '0;
          rem_next = '0; fix_next = '0;
        end
      end

      default: begin
        phase_next = PH_TAG;
        acc_next = '0; cnt_next = '0; fld_next = '0; wt_next = '0;
        rem_next = '0; fix_next = '0;
      end
    endcase

    // Buffer ends inside a field: append a truncation record and resync
    if (end_of_buffer && !(phase_next == PH_TAG && cnt_next == 4'd0)) begin
      if (p0) begin
        p1 = 1'b1;
        r1.kind  = KIND_TRUNC;
        r1.field = fld_next;
        r1.value = '0;
      end else begin
        p0 = 1'b1;
        r0.kind  = KIND_TRUNC;
        r0.field = fld_next;
        r0.value = '0;
      end
      phase_next = PH_TAG;
      acc_next = '0; cnt_next = '0; fld_next = '0; wt_next = '0;
      rem_next = '0; fix_next = '0;
    end

    r0.last = !p1;
    r1.last = 1'b1;
  end

  assign push.push0 = take && p0;
  assign push.push1 = take && p1;
  assign push.rec0  = r0;
  assign push.rec1  = r1;

  // Advance the parser state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_TAG;
      acc     <= '0;
      cnt     <= '0;
      fld     <= '0;
      wt      <= '0;
      rem     <= '0;
      plen    <= '0;
      fix     <= '0;
      u_pend  <= '0;
      u_valid <= 1'b1;
      u_stop  <= 1'b0;
    end else if (take) begin
      phase   <= phase_next;
      acc     <= acc_next;
      cnt     <= cnt_next;
      fld     <= fld_next;
      wt      <= wt_next;
      rem     <= rem_next;
      plen    <= plen_next;
      fix     <= fix_next;
      u_pend  <= u_pend_next;
      u_valid <= u_valid_next;
      u_stop  <= u_stop_next;
    end
  end

endmodule

### rtl/wftok_fifo.sv
module wftok_fifo
  import wftok_pkg::*;
#(
  parameter int unsigned FifoDepth = WFT_FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    full2,
  output logic    rd_valid,
  input  logic    rd_take,
  output record_t rd_rec
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FifoDepth - 1);

  record_t         mem [FifoDepth];
  logic [PtrW-1:0] wr, wr_p1, wr_p2, rd, rd_next;
  logic [CntW-1:0] count, count_next;

  assign wr_p1   = (wr == LastPtr) ? '0 : wr + PtrW'(1);
  assign wr_p2   = (wr_p1 == LastPtr) ? '0 : wr_p1 + PtrW'(1);
  assign rd_next = (rd == LastPtr) ? '0 : rd + PtrW'(1);

  assign rd_valid = (count != '0);
  assign rd_rec   = mem[rd];
  // Hold off requests unless two entries are free
  assign full2    = (count > CntW'(FifoDepth - 2));

  always_comb begin
    count_next = count + CntW'(push.push0) + CntW'(push.push1)
                 - CntW'(rd_take && rd_valid);
  end

  // Store the records of one request
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr] <= push.rec0;
    end
    if (push.push1) begin
      mem[wr_p1] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push.push1) begin
        wr <= wr_p2;
      end else if (push.push0) begin
        wr <= wr_p1;
      end
      if (rd_take && rd_valid) begin
        rd <= rd_next;
      end
      count <= count_next;
    end
  end

endmodule
